/* src/assert_macros.svh */
// Assertion helpers for the stack calculator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge, muted during reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* src/rpn_pkg.sv */
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared constants, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none
package rpn_pkg;
    localparam int STACK_DEPTH = 16;
    localparam int PTR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [3:0] CMD_PUSH = 4'd0;
    localparam logic [3:0] CMD_TOP = 4'd1;
    localparam logic [3:0] CMD_POP = 4'd2;
    localparam logic [3:0] CMD_ALL = 4'd3;
    localparam logic [3:0] CMD_CLEAR = 4'd4;
    localparam logic [3:0] CMD_DUP = 4'd5;
    localparam logic [3:0] CMD_SWAP = 4'd6;
    localparam logic [3:0] CMD_ADD = 4'd7;
    localparam logic [3:0] CMD_SUB = 4'd8;
    localparam logic [3:0] CMD_MUL = 4'd9;
    localparam logic [3:0] CMD_DIV = 4'd10;
    localparam logic [3:0] CMD_REM = 4'd11;

    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_FULL = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;
    localparam logic [1:0] KIND_DIVZERO = 2'd3;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_RD,      // read stack at addr, result in rd_data next cycle
        OP_WR,      // write the src-selected data at addr
        OP_LDB,     // latch read data into operand b
        OP_LDA,     // latch read data into operand a
        OP_ALU,     // load add/sub/mul, swap or divider output into result
        OP_DIV      // start the iterative divider
    } t_op;

    typedef enum logic [1:0] {
        SRC_PUSH,
        SRC_RD,
        SRC_A,
        SRC_RES
    } t_src;

    typedef struct packed {
        t_op               op;
        logic [PTR_W-1:0]  addr;
        t_src              src;
        logic [3:0]        cmd;
        logic [DATA_W-1:0] push_value;
    } t_dp_cmd;

    typedef struct packed {
        logic              div_busy;
        logic              div_zero;
        logic [DATA_W-1:0] rd_data;
    } t_dp_stat;
endpackage
`default_nettype wire

/* src/rpn_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* src/rpn_div.sv */
// ----------------------------------------------------------------------------
// RPN divider
// Restoring signed division, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none
module rpn_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [rpn_pkg::DATA_W-1:0] i_a,
    input  wire logic [rpn_pkg::DATA_W-1:0] i_b,
    output logic                            o_busy,
    output logic      [rpn_pkg::DATA_W-1:0] o_quot,
    output logic      [rpn_pkg::DATA_W-1:0] o_rem
);
    import rpn_pkg::*;
    localparam int STEP_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] r_q, r_d;
    logic [DATA_W:0]   r_r;
    logic [STEP_W-1:0] r_cnt;
    logic              r_sq, r_sr;
    logic [DATA_W-1:0] abs_a, abs_b;
    logic [DATA_W:0]   n_r, trial;

    assign abs_a = i_a[DATA_W-1] ? (~i_a + 1'b1) : i_a;
    assign abs_b = i_b[DATA_W-1] ? (~i_b + 1'b1) : i_b;
    assign n_r   = {r_r[DATA_W-1:0], r_q[DATA_W-1]};
    assign trial = n_r - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= STEP_W'(DATA_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_start) begin
            r_q  <= abs_a;
            r_d  <= abs_b;
            r_r  <= '0;
            r_sq <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
            r_sr <= i_a[DATA_W-1];
        end else if (r_cnt != '0) begin
            if (!trial[DATA_W]) begin
                r_r <= trial;
                r_q <= {r_q[DATA_W-2:0], 1'b1};
            end else begin
                r_r <= n_r;
                r_q <= {r_q[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_sq ? (~r_q + 1'b1) : r_q;
    assign o_rem  = r_sr ? (~r_r[DATA_W-1:0] + 1'b1) : r_r[DATA_W-1:0];
endmodule
`default_nettype wire

/* src/rpn_datapath.sv */
// ----------------------------------------------------------------------------
// RPN datapath
// Stack RAM, operand registers, ALU with registered multiply and divider.
// ----------------------------------------------------------------------------
`default_nettype none
module rpn_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rpn_pkg::t_dp_cmd  i_cmd,
    output rpn_pkg::t_dp_stat      o_stat
);
    import rpn_pkg::*;

    logic [DATA_W-1:0] r_a, r_b, r_res, rd_data, wdata, quot, remd;
    logic              we, div_busy;

    assign we = (i_cmd.op == OP_WR);

    always_comb begin
        case (i_cmd.src)
            SRC_PUSH: wdata = i_cmd.push_value;
            SRC_RD:   wdata = rd_data;
            SRC_A:    wdata = r_a;
            SRC_RES:  wdata = r_res;
            default:  wdata = r_res;
        endcase
    end

    rpn_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_cmd.addr),
        .i_wdata (wdata),
        .i_raddr (i_cmd.addr),
        .o_rdata (rd_data)
    );

    rpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIV),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_busy  (div_busy),
        .o_quot  (quot),
        .o_rem   (remd)
    );

    // operand and result registers: read data into b or a; ALU op, swap, or divider output once it has settled
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LDB: r_b <= rd_data;
            OP_LDA: r_a <= rd_data;
            OP_ALU: begin
                case (i_cmd.cmd)
                    CMD_SWAP: r_res <= r_b;
                    CMD_ADD: r_res <= r_a + r_b;
                    CMD_SUB: r_res <= r_a - r_b;
                    CMD_MUL: r_res <= r_a * r_b;
                    CMD_DIV: r_res <= quot;
                    default: r_res <= remd;
                endcase
            end
            default: ;
        endcase
    end

    assign o_stat.div_busy = div_busy;
    assign o_stat.div_zero = (r_b == '0);
    assign o_stat.rd_data  = rd_data;
endmodule
`default_nettype wire

/* src/rpn_ctrl.sv */
// ----------------------------------------------------------------------------
// RPN controller
// Sequences each command through the datapath and issues result items.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rpn_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [3:0]                 i_command,
    input  wire logic [rpn_pkg::DATA_W-1:0] i_push_value,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic      [1:0]                 o_kind,
    output logic      [rpn_pkg::DATA_W-1:0] o_value,
    output logic                            o_last,
    output rpn_pkg::t_dp_cmd                o_cmd,
    input  wire rpn_pkg::t_dp_stat          i_stat
);
    import rpn_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RDB, S_LDB, S_RDA, S_LDA, S_EXEC, S_DIVW, S_WB,
        S_SWAP2, S_DUPW, S_TOPW, S_ALLR, S_ALLW, S_EMIT
    } t_state;

    t_state            r_state;
    logic [3:0]        r_cmdc;
    logic [CNT_W-1:0]  r_cnt, r_idx;
    logic              r_ovalid, r_olast, r_all;
    logic [1:0]        r_okind;
    logic [DATA_W-1:0] r_oval;
    t_op               op;
    t_src              src;
    logic [PTR_W-1:0]  addr;
    logic              out_free;

    assign out_free   = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;

    // datapath command decode per state
    always_comb begin
        op   = OP_NONE;
        src  = SRC_PUSH;
        addr = '0;
        case (r_state)
            S_IDLE: begin
                addr = PTR_W'(i_command == CMD_PUSH ? r_cnt : r_cnt - 1'b1);
                if (i_in_valid && o_in_ready) begin
                    if (i_command == CMD_PUSH && r_cnt != CNT_W'(STACK_DEPTH)) begin
                        op = OP_WR;
                    end else if (i_command != CMD_PUSH) begin
                        op = OP_RD;
                    end
                end
            end
            S_RDB:  begin op = OP_RD; addr = PTR_W'(r_cnt - 1'b1); end
            S_LDB:  op = OP_LDB;
            S_RDA:  begin op = OP_RD; addr = PTR_W'(r_cnt - 1'b1); end
            S_LDA:  op = OP_LDA;
            S_EXEC: op = (r_cmdc == CMD_DIV || r_cmdc == CMD_REM) ? OP_DIV : OP_ALU;
            S_DIVW: op = i_stat.div_busy ? OP_NONE : OP_ALU;
            S_WB:   begin op = OP_WR; src = SRC_RES; addr = PTR_W'(r_cnt); end
            S_SWAP2: begin op = OP_WR; src = SRC_A; addr = PTR_W'(r_cnt); end
            S_DUPW: begin op = OP_WR; src = SRC_RD; addr = PTR_W'(r_cnt); end
            S_ALLR: begin op = OP_RD; addr = PTR_W'(r_idx - 1'b1); end
            default: ;
        endcase
    end

    assign o_cmd = '{op: op, addr: addr, src: src, cmd: r_cmdc, push_value: i_push_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_cmdc <= i_command;
                        case (i_command)
                            CMD_PUSH: begin
                                if (r_cnt == CNT_W'(STACK_DEPTH)) begin
                                    r_ovalid <= 1'b1; r_okind <= KIND_FULL;
                                    r_oval <= '0; r_olast <= 1'b1;
                                end else r_cnt <= r_cnt + 1'b1;
                            end
                            CMD_TOP, CMD_POP: begin
                                if (r_cnt == '0) begin
                                    r_ovalid <= 1'b1; r_okind <= KIND_EMPTY;
                                    r_oval <= '0; r_olast <= 1'b1;
                                end else begin
                                    if (i_command == CMD_POP) r_cnt <= r_cnt - 1'b1;
                                    r_state <= S_TOPW;
                                end
                            end
                            CMD_DUP: begin
                                if (r_cnt == '0) begin
                                    r_ovalid <= 1'b1; r_okind <= KIND_EMPTY;
                                    r_oval <= '0; r_olast <= 1'b1;
                                end else if (r_cnt == CNT_W'(STACK_DEPTH)) begin
                                    r_ovalid <= 1'b1; r_okind <= KIND_FULL;
                                    r_oval <= '0; r_olast <= 1'b1;
                                end else r_state <= S_DUPW;
                            end
                            CMD_ALL: begin
                                r_idx <= r_cnt;
                                if (r_cnt != '0) r_state <= S_ALLR;
                            end
                            CMD_CLEAR: r_cnt <= '0;
                            CMD_SWAP, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_REM: begin
                                if (r_cnt < CNT_W'(2)) begin
                                    r_cnt <= '0;
                                    r_ovalid <= 1'b1; r_okind <= KIND_EMPTY;
                                    r_oval <= '0; r_olast <= 1'b1;
                                end else begin
                                    r_cnt <= r_cnt - 1'b1;
                                    r_state <= S_LDB;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_LDB: r_state <= S_RDA;
                S_RDA: begin r_cnt <= r_cnt - 1'b1; r_state <= S_LDA; end
                // swap passes b through the result register, then writes a
                S_LDA: r_state <= S_EXEC;
                S_EXEC: begin
                    if ((r_cmdc == CMD_DIV || r_cmdc == CMD_REM) && i_stat.div_zero) begin
                        r_state <= S_EMIT; r_okind <= KIND_DIVZERO;
                    end else if (r_cmdc == CMD_DIV || r_cmdc == CMD_REM) begin
                        r_state <= S_DIVW;
                    end else r_state <= S_WB;
                end
                S_DIVW: if (!i_stat.div_busy) r_state <= S_WB;
                S_WB: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_state <= (r_cmdc == CMD_SWAP) ? S_SWAP2 : S_IDLE;
                end
                S_SWAP2: begin r_cnt <= r_cnt + 1'b1; r_state <= S_IDLE; end
                S_DUPW: begin r_cnt <= r_cnt + 1'b1; r_state <= S_IDLE; end
                S_TOPW: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1; r_okind <= KIND_VALUE;
                        r_oval <= i_stat.rd_data; r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_ALLR: begin
                    if (out_free) begin
                        r_idx <= r_idx - 1'b1;
                        r_state <= S_ALLW;
                    end
                end
                S_ALLW: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1; r_okind <= KIND_VALUE;
                        r_oval <= i_stat.rd_data; r_olast <= (r_idx == '0);
                        r_state <= (r_idx == '0) ? S_IDLE : S_ALLR;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1; r_oval <= '0; r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // S_RDB is unused: the first read is issued from idle
    assign r_all = (r_state == S_RDB);

    assign o_out_valid = r_ovalid;
    assign o_kind      = r_okind;
    assign o_value     = r_oval;
    assign o_last      = r_olast;

    `CHK_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(STACK_DEPTH) && !r_all,
        "stack count out of range")
    `CHK_IMPL(a_busy_ready, i_clk, i_rst_n, r_state != S_IDLE, !o_in_ready,
        "input taken while busy")
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_value), "result dropped")
endmodule
`default_nettype wire

/* src/rpn_stack_calculator_unit.sv */
// ----------------------------------------------------------------------------
// RPN stack calculator
// Divide and remainder wait on the iterative divider for their result.
// Flow: one command at a time; print all reads and then emits each entry
//   through the single registered read port; a waiting result holds off input.
// Reset: synchronous active low; empties the stack, stack contents undefined.
// ----------------------------------------------------------------------------
`default_nettype none
module rpn_stack_calculator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [3:0] command, [35:4] push_value, [39:36] zero
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] result_value
    output logic      [31:0] m_axis_tdata,
    // [1:0] kind
    output logic      [1:0]  m_axis_tuser,
    output logic             m_axis_tlast
);
    import rpn_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // controller: sequences commands and holds the output registers
    rpn_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_command    (s_axis_tdata[3:0]),
        .i_push_value (s_axis_tdata[35:4]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_kind       (m_axis_tuser),
        .o_value      (m_axis_tdata),
        .o_last       (m_axis_tlast),
        .o_cmd        (dp_cmd),
        .i_stat       (dp_stat)
    );

    // datapath: stack RAM, operands, ALU and divider
    rpn_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat)
    );
endmodule
`default_nettype wire

/* sim/tb_rpn_stack_calculator_unit.sv */
// ----------------------------------------------------------------------------
// RPN stack calculator testbench
// Drives command transfers with random gaps and back-pressure, predicts every
// printed value and error with an independent stack model, and checks each
// result transfer in order against the predictions.
// ----------------------------------------------------------------------------
`default_nettype none

class calc_scoreboard;
    logic [31:0] stack_q [rpn_pkg::STACK_DEPTH];
    int unsigned depth;
    logic [34:0] pending_q [$];   // {last, kind, value}
    int unsigned mismatches;

    function new();
        depth = 0;
        mismatches = 0;
    endfunction

    function void note_result(logic [1:0] kind, logic [31:0] value, logic is_last);
        pending_q.push_back({is_last, kind, value});
    endfunction

    // predict the results of one accepted command
    function void note_command(logic [3:0] cmd, logic [31:0] pv);
        logic [31:0] a, b, r;
        int i;
        longint sa, sb;
        a = 0;
        b = 0;
        r = 0;
        case (cmd)
            rpn_pkg::CMD_PUSH: begin
                if (depth >= rpn_pkg::STACK_DEPTH) note_result(rpn_pkg::KIND_FULL, 0, 1);
                else begin
                    stack_q[depth] = pv;
                    depth++;
                end
            end
            rpn_pkg::CMD_TOP: begin
                if (depth == 0) note_result(rpn_pkg::KIND_EMPTY, 0, 1);
                else note_result(rpn_pkg::KIND_VALUE, stack_q[depth-1], 1);
            end
            rpn_pkg::CMD_POP: begin
                if (depth == 0) note_result(rpn_pkg::KIND_EMPTY, 0, 1);
                else begin
                    depth--;
                    note_result(rpn_pkg::KIND_VALUE, stack_q[depth], 1);
                end
            end
            rpn_pkg::CMD_ALL: begin
                for (i = depth - 1; i >= 0; i--)
                    note_result(rpn_pkg::KIND_VALUE, stack_q[i], i == 0);
            end
            rpn_pkg::CMD_CLEAR: depth = 0;
            rpn_pkg::CMD_DUP: begin
                if (depth == 0) note_result(rpn_pkg::KIND_EMPTY, 0, 1);
                else if (depth >= rpn_pkg::STACK_DEPTH) note_result(rpn_pkg::KIND_FULL, 0, 1);
                else begin
                    stack_q[depth] = stack_q[depth-1];
                    depth++;
                end
            end
            rpn_pkg::CMD_SWAP, rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL,
            rpn_pkg::CMD_DIV, rpn_pkg::CMD_REM: begin
                if (depth < 2) begin
                    // popped operands are lost
                    depth = 0;
                    note_result(rpn_pkg::KIND_EMPTY, 0, 1);
                end else begin
                    b = stack_q[depth-1];
                    a = stack_q[depth-2];
                    depth -= 2;
                    sa = $signed(a);
                    sb = $signed(b);
                    if (cmd == rpn_pkg::CMD_SWAP) begin
                        stack_q[depth] = b;
                        stack_q[depth+1] = a;
                        depth += 2;
                    end else if ((cmd == rpn_pkg::CMD_DIV || cmd == rpn_pkg::CMD_REM) && sb == 0)
                        note_result(rpn_pkg::KIND_DIVZERO, 0, 1);
                    else begin
                        case (cmd)
                            rpn_pkg::CMD_ADD: r = a + b;
                            rpn_pkg::CMD_SUB: r = a - b;
                            rpn_pkg::CMD_MUL: r = a * b;
                            rpn_pkg::CMD_DIV: r = 32'(sa / sb);
                            default:          r = 32'(sa % sb);
                        endcase
                        stack_q[depth] = r;
                        depth++;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [31:0] value, logic is_last);
        logic [34:0] exp_r;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result kind=%0d value=%h last=%b", kind, value, is_last);
            return;
        end
        exp_r = pending_q.pop_front();
        if (exp_r !== {is_last, kind, value}) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected kind=%0d value=%h last=%b, got kind=%0d value=%h last=%b",
                         exp_r[33:32], exp_r[31:0], exp_r[34], kind, value, is_last);
        end
    endfunction
endclass

module tb_rpn_stack_calculator_unit;
    import rpn_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    calc_scoreboard calc_sb = new();
    bit quiet_phase = 0;    // long stretch without idling on either side
    int unsigned idle_cycles = 0;

    rpn_stack_calculator_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // receiver: random back-pressure, check each result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            calc_sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        m_axis_tready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 37);
    end

    // watchdog: count cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("rpn_stack_calculator_unit test failed");
            $finish;
        end
    end

    // sometimes idle for a random gap, then hold one command until it is transferred
    // and note it for prediction; valid stays high into the next command
    task automatic send_command(input logic [3:0] cmd, input logic [31:0] pv);
        if (!quiet_phase && $urandom_range(99) < 37) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 37);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, pv, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        calc_sb.note_command(cmd, pv);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'(int'($urandom_range(20)) - 10);
            4: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int n;
        int k;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-stack errors, extremes, division corners, overflow
        send_command(CMD_TOP, 0);
        send_command(CMD_POP, 0);
        send_command(CMD_DUP, 0);
        send_command(CMD_ALL, 0);
        send_command(CMD_PUSH, 32'h7FFF_FFFF);
        send_command(CMD_ADD, 0);            // one operand: underflow, stack lost
        send_command(CMD_PUSH, 32'h8000_0000);
        send_command(CMD_PUSH, 32'hFFFF_FFFF);
        send_command(CMD_DIV, 0);            // wraps to most negative
        send_command(CMD_DUP, 0);
        send_command(CMD_PUSH, 32'hFFFF_FFFF);
        send_command(CMD_REM, 0);
        send_command(CMD_PUSH, 0);
        send_command(CMD_DIV, 0);            // divide by zero
        send_command(CMD_PUSH, -7);
        send_command(CMD_PUSH, 2);
        send_command(CMD_REM, 0);
        send_command(CMD_PUSH, 32'hFFFF_FFFF);
        send_command(CMD_SWAP, 32'hFFFF_FFFF);
        send_command(4'd15, 32'hFFFF_FFFF);  // unused code: ignored
        for (k = 0; k < 17; k++) send_command(CMD_PUSH, $urandom()); // fill, then overflow
        send_command(CMD_DUP, 0);
        send_command(CMD_ALL, 0);
        send_command(CMD_CLEAR, 0);

        // random: mostly well-formed bursts, some noise
        n = 0;
        while (n < 360) begin
            quiet_phase = (n >= 150 && n < 200);
            if ($urandom_range(99) < 70) begin
                // push a few operands then operate on them
                repeat ($urandom_range(3, 1)) begin
                    send_command(CMD_PUSH, rand_value());
                    n++;
                end
                send_command(4'($urandom_range(CMD_DUP, CMD_REM)), $urandom());
                n++;
                if ($urandom_range(3) == 0) begin
                    send_command(4'($urandom_range(CMD_TOP, CMD_ALL)), $urandom());
                    n++;
                end
            end else begin
                send_command(4'($urandom_range(15)), $urandom());
                n++;
            end
        end
        quiet_phase = 0;
        send_command(CMD_ALL, 0);
        s_axis_tvalid <= 1'b0;

        // drain outstanding results, then allow for the divider latency
        while (calc_sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (calc_sb.mismatches == 0 && calc_sb.pending_q.size() == 0)
            $display("rpn_stack_calculator_unit test passed");
        else
            $display("rpn_stack_calculator_unit test failed");
        $finish;
    end
endmodule

`default_nettype wire
